[hw/rtl/mmsb_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmsb_pkg
// Shared constants, codes and types of the min/max byte stretcher.
// -----------------------------------------------------------------------------
package mmsb_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int MARK_BITS    = SAMPLE_BITS + 1;
   localparam int SAMPLE_W     = 16;
   localparam int CMD_W        = 2;
   localparam int PIXEL_W      = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 3;
   localparam int SPP_W        = 3;
   localparam int CH_W         = 2;
   localparam int MAX_CHANNELS = 4;
   localparam int DIV_STEPS    = PIXEL_W;
   localparam int STEP_W       = $clog2(DIV_STEPS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIXEL_W-1:0] PIXEL_FULL = {PIXEL_W{1'b1}};
   localparam logic [PIXEL_W-1:0] PIXEL_ZERO = '0;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_RESTART = 2'd0;
   localparam cmd_type CMD_MEASURE = 2'd1;
   localparam cmd_type CMD_CONVERT = 2'd2;
   localparam cmd_type CMD_UNUSED  = 2'd3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SAMPLES_PER_PIXEL = 2'd0;
   localparam csr_index_type CSR_SAMPLE_SIGNED     = 2'd1;

   typedef logic [1:0] job_kind_type;
   localparam job_kind_type JOB_ZERO   = 2'd0;
   localparam job_kind_type JOB_FULL   = 2'd1;
   localparam job_kind_type JOB_DIVIDE = 2'd2;

   typedef struct packed {
      logic [SPP_W-1:0] samples_per_pixel;
      logic             sample_signed;
   } cfg_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [MARK_BITS-1:0] delta;
      logic [MARK_BITS-1:0] span;
   } job_type;

endpackage

[hw/rtl/mmsb_channels_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmsb channel interfaces
// Valid/ready channels for commands, stretched pixels and register writes.
// -----------------------------------------------------------------------------
interface mmsb_req_if import mmsb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, cmd, sample, input ready);
   modport sink   (input valid, cmd, sample, output ready);
endinterface

interface mmsb_rsp_if import mmsb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, pixel, input ready);
   modport sink   (input valid, pixel, output ready);
endinterface

interface mmsb_csr_if import mmsb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/min_max_stretch_to_byte.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// min_max_stretch_to_byte
// Two-pass auto-contrast of one slice of samples down to 8-bit pixels.
// -----------------------------------------------------------------------------
// Usage:
//   req_if : one transaction per raw sample; cmd restarts the slice, measures
//            a sample into the running min/max, or converts it to a pixel.
//            Only channel zero of each pixel counts (samples_per_pixel).
//   rsp_if : one transaction per converted channel-zero sample, carrying
//            floor((v-min)*255/span) clamped to 0..255.
//   csr_if : register writes, index 0 samples_per_pixel, 1 sample_signed;
//            always ready. Write only while no conversion is in flight.
// Flow:
//   Restart and measure transactions are taken one per cycle while the job
//   queue is not full. A converted sample that clamps to 0 or 255 passes
//   through the queue into the output register without division; one in range
//   goes through an 8-step serial divider first, which takes no new job until
//   it has handed its quotient to the output register. A two-entry job queue
//   lets the front keep taking input while the divider works.
// Reset: min/max return to the unsigned extremes, samples_per_pixel to 1,
//   sample_signed to 0, queue and divider empty.
// Stall: when rsp_if.ready is low the pixel holds in the output register,
//   the divider holds its result, and req_if.ready drops once the queue fills.
// -----------------------------------------------------------------------------
module min_max_stretch_to_byte import mmsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mmsb_req_if.sink   req_if,
   mmsb_rsp_if.source rsp_if,
   mmsb_csr_if.sink   csr_if
);

   logic [SPP_W-1:0] spp_ff, spp_in;
   logic             signed_ff, signed_in;
   cfg_type          cfg;

   logic             queue_full;
   logic             push;
   job_type          push_job;
   logic             pop;
   logic             head_valid;
   job_type          head_job;

   // register writes take effect in the following cycle; unknown indexes drop silently
   assign csr_if.ready = 1'b1;

   always_comb begin
      spp_in    = spp_ff;
      signed_in = signed_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_SAMPLES_PER_PIXEL: spp_in    = csr_if.data[SPP_W-1:0];
            CSR_SAMPLE_SIGNED:     signed_in = csr_if.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff    <= SPP_W'(1);
         signed_ff <= 1'b0;
      end else begin
         spp_ff    <= spp_in;
         signed_ff <= signed_in;
      end
   end

   assign cfg.samples_per_pixel = spp_ff;
   assign cfg.sample_signed     = signed_ff;

   // classify incoming samples and track the measured range
   mmsb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_if),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // decouple classifier from divider
   mmsb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // divide and hand pixels out
   mmsb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

[hw/rtl/mmsb_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmsb_front
// Accepts commands, tracks min/max and channel count, classifies pixels.
// -----------------------------------------------------------------------------
module mmsb_front import mmsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   mmsb_req_if.sink req,
   input  logic    queue_full,
   output logic    push,
   output job_type job
);

   logic signed [MARK_BITS-1:0] low_ff, low_in;
   logic signed [MARK_BITS-1:0] high_ff, high_in;
   logic [CH_W-1:0]             ch_ff, ch_in;
   logic                        conv_ff, conv_in;

   logic [SAMPLE_BITS-1:0]      raw_bits;
   logic signed [MARK_BITS-1:0] sample_val;
   logic signed [MARK_BITS-1:0] greatest;
   logic signed [MARK_BITS-1:0] least;
   logic [SPP_W-1:0]            ch_count;
   logic [SPP_W-1:0]            ch_plus;
   logic [SPP_W-1:0]            ch_mod;
   logic [CH_W-1:0]             ch_eff;
   logic                        accept;
   logic                        pass_change;
   logic [MARK_BITS-1:0]        span_raw;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign raw_bits   = req.sample[SAMPLE_BITS-1:0];
   assign sample_val = {cfg.sample_signed & raw_bits[SAMPLE_BITS-1], raw_bits};

   assign greatest = cfg.sample_signed ? {2'b00, {(SAMPLE_BITS-1){1'b1}}}
                                       : {1'b0, {SAMPLE_BITS{1'b1}}};
   assign least    = cfg.sample_signed ? {2'b11, {(SAMPLE_BITS-1){1'b0}}}
                                       : '0;

   assign ch_count = (cfg.samples_per_pixel == '0) ? SPP_W'(1) :
                     (cfg.samples_per_pixel > SPP_W'(MAX_CHANNELS)) ? SPP_W'(MAX_CHANNELS) :
                     cfg.samples_per_pixel;

   assign pass_change = (req.cmd == CMD_MEASURE && conv_ff) ||
                        (req.cmd == CMD_CONVERT && !conv_ff);
   assign ch_eff      = pass_change ? '0 : ch_ff;

   // wrap the channel counter; ch+1 never exceeds twice the count unless count is one
   always_comb begin
      ch_plus = SPP_W'(ch_eff) + SPP_W'(1);
      ch_mod  = (ch_plus >= ch_count) ? ch_plus - ch_count : ch_plus;
      ch_mod  = (ch_mod >= ch_count) ? ch_mod - ch_count : ch_mod;
      if (ch_count == SPP_W'(1)) begin
         ch_mod = '0;
      end
   end

   // classify a pixel against the measured range
   assign span_raw = MARK_BITS'(high_ff - low_ff);

   always_comb begin
      job.delta = MARK_BITS'(sample_val - low_ff);
      job.span  = (high_ff > low_ff) ? span_raw : MARK_BITS'(1);
      if (sample_val <= low_ff) begin
         job.kind = JOB_ZERO;
      end else if (job.delta >= job.span) begin
         job.kind = JOB_FULL;
      end else begin
         job.kind = JOB_DIVIDE;
      end
   end

   assign push = accept && (req.cmd == CMD_CONVERT) && (ch_eff == '0);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      ch_in   = ch_ff;
      conv_in = conv_ff;
      if (accept) begin
         case (req.cmd)
            CMD_RESTART: begin
               low_in  = greatest;
               high_in = least;
               ch_in   = '0;
               conv_in = 1'b0;
            end
            CMD_MEASURE, CMD_CONVERT: begin
               conv_in = (req.cmd == CMD_CONVERT);
               ch_in   = ch_mod[CH_W-1:0];
               if (req.cmd == CMD_MEASURE && ch_eff == '0) begin
                  if (sample_val < low_ff) begin
                     low_in = sample_val;
                  end
                  if (sample_val > high_ff) begin
                     high_in = sample_val;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= {1'b0, {SAMPLE_BITS{1'b1}}};
         high_ff <= '0;
         ch_ff   <= '0;
         conv_ff <= 1'b0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         ch_ff   <= ch_in;
         conv_ff <= conv_in;
      end
   end

endmodule

[hw/rtl/mmsb_queue.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmsb_queue
// Two-entry job queue between classifier and divider.
// -----------------------------------------------------------------------------
module mmsb_queue import mmsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

[hw/rtl/mmsb_back.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmsb_back
// Serial restoring divider producing (delta*255)/span, plus output register.
// -----------------------------------------------------------------------------
module mmsb_back import mmsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   mmsb_rsp_if.source rsp
);

   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [MARK_BITS-1:0]    rem_ff, rem_in;
   logic [MARK_BITS-1:0]    span_ff, span_in;
   logic [PIXEL_W-1:0]      numer_ff, numer_in;
   logic [PIXEL_W-1:0]      quo_ff, quo_in;
   logic                    out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]      pixel_ff, pixel_in;

   logic                    out_free;
   logic [MARK_BITS+PIXEL_W-1:0] product;
   logic [MARK_BITS:0]      trial;
   logic                    fits;
   logic [MARK_BITS:0]      trial_diff;

   assign out_free = !out_valid_ff || rsp.ready;
   assign pop      = head_valid && !busy_ff && out_free;

   // delta * (2^PIXEL_W - 1) as shift and subtract
   assign product = {head_job.delta, PIXEL_W'(0)} - (MARK_BITS+PIXEL_W)'(head_job.delta);

   assign trial      = {rem_ff, numer_ff[PIXEL_W-1]};
   assign fits       = (trial >= {1'b0, span_ff});
   assign trial_diff = trial - {1'b0, span_ff};

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      numer_in     = numer_ff;
      quo_in       = quo_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pixel_in     = pixel_ff;
      if (pop) begin
         case (head_job.kind)
            JOB_DIVIDE: begin
               busy_in  = 1'b1;
               step_in  = STEP_W'(DIV_STEPS);
               rem_in   = product[MARK_BITS+PIXEL_W-1:PIXEL_W];
               numer_in = product[PIXEL_W-1:0];
               span_in  = head_job.span;
               quo_in   = '0;
            end
            JOB_FULL: begin
               out_valid_in = 1'b1;
               pixel_in     = PIXEL_FULL;
            end
            default: begin
               out_valid_in = 1'b1;
               pixel_in     = PIXEL_ZERO;
            end
         endcase
      end else if (busy_ff && step_ff != '0) begin
         rem_in   = fits ? trial_diff[MARK_BITS-1:0] : trial[MARK_BITS-1:0];
         quo_in   = {quo_ff[PIXEL_W-2:0], fits};
         numer_in = {numer_ff[PIXEL_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
      end else if (busy_ff && out_free) begin
         busy_in      = 1'b0;
         out_valid_in = 1'b1;
         pixel_in     = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      span_ff  <= span_in;
      numer_ff <= numer_in;
      quo_ff   <= quo_in;
      pixel_ff <= pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pixel = pixel_ff;

`ifndef SYNTHESIS
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < span_ff))
      else $error("divider remainder not below divisor");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == '0 && !out_free) |=> busy_ff)
      else $error("divider finished while output register was held");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_W'(DIV_STEPS)))
      else $error("divider step count out of range");
`endif

endmodule
